>>> rtl/swam_pkg.sv
// ----------------------------------------------------------------------------
// swam_pkg
// Shared types and constants for the sensor window average monitor.
// ----------------------------------------------------------------------------
package swam_pkg;

	localparam int TABLE_DEPTH   = 16;
	localparam int WINDOW_LENGTH = 5;

	localparam int SLOT_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W    = $clog2(WINDOW_LENGTH + 1);
	localparam int WIN_DEPTH = TABLE_DEPTH * WINDOW_LENGTH;
	localparam int WIN_AW   = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

	// window sum, its magnitude and the reciprocal divide
	localparam int SUM_W  = 17 + $clog2(WINDOW_LENGTH);
	localparam int MAG_W  = SUM_W - 1;
	localparam int SH     = MAG_W;
	localparam int PROD_W = MAG_W + SH + 1;
	localparam logic [SH:0] RECIP = (SH + 1)'((64'd1 << SH) / WINDOW_LENGTH);

	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_THRESHOLD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_THRESHOLD = 8'd1;

	localparam logic FUNC_MAP    = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	localparam logic [2:0] ST_MAPPED    = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_UNMAPPED  = 3'd3;
	localparam logic [2:0] ST_STORED    = 3'd4;

	typedef struct packed {
		logic               func;
		logic [15:0]        probe_id;
		logic [15:0]        room;
		logic signed [15:0] sample_value;
		logic [31:0]        sample_time;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [15:0]        room_of_sensor;
		logic signed [15:0] average;
		logic               average_valid;
		logic               too_hot;
		logic               too_cold;
		logic [31:0]        last_time;
	} rsp_t;

	typedef struct packed {
		logic               en;
		logic [WIN_AW-1:0]  addr;
		logic signed [15:0] data;
	} win_wr_t;

	typedef struct packed {
		logic              start;
		logic [WIN_AW-1:0] base;
	} win_cmd_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] avg;
	} win_res_t;

endpackage

>>> rtl/swam_window.sv
// ----------------------------------------------------------------------------
// swam_window
// Sample ring storage for all slots, with a sequential window sum and a
// divide by the window length, truncated toward zero.
// ----------------------------------------------------------------------------
module swam_window import swam_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  win_wr_t  wr,
	input  win_cmd_t cmd,
	output win_res_t res
);

	localparam logic [2:0] P_IDLE  = 3'd0;
	localparam logic [2:0] P_READ  = 3'd1;
	localparam logic [2:0] P_DRAIN = 3'd2;
	localparam logic [2:0] P_MUL   = 3'd3;
	localparam logic [2:0] P_FIX   = 3'd4;
	localparam logic [2:0] P_DONE  = 3'd5;

	logic signed [15:0] mem [WIN_DEPTH];

	logic [2:0]         ph_q;
	logic [WIN_AW-1:0]  rd_addr_q;
	logic [CNT_W-1:0]   issue_q;
	logic               rd_vld_q;
	logic signed [15:0] rd_data_q;
	logic signed [SUM_W-1:0] acc_q;
	logic [MAG_W-1:0]   mag_q;
	logic               neg_q;
	logic [PROD_W-1:0]  prod_q;
	logic signed [15:0] avg_q;

	logic [MAG_W-1:0] mag;
	logic [MAG_W-1:0] q_est;
	logic [MAG_W-1:0] rem;
	logic [MAG_W-1:0] q_fix;

	always_comb begin
		mag   = acc_q[SUM_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);
		q_est = prod_q[SH +: MAG_W];
		rem   = mag_q - MAG_W'(q_est * WINDOW_LENGTH);
		// reciprocal estimate is low by at most one
		q_fix = q_est + MAG_W'(rem >= MAG_W'(WINDOW_LENGTH));
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (ph_q == P_READ) begin
			rd_data_q <= mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= P_IDLE;
			rd_vld_q <= 1'b0;
			issue_q  <= '0;
		end else begin
			rd_vld_q <= (ph_q == P_READ);
			case (ph_q)
				P_IDLE: begin
					if (cmd.start) begin
						issue_q <= '0;
						ph_q    <= P_READ;
					end
				end
				P_READ: begin
					issue_q <= issue_q + 1'b1;
					if (issue_q == CNT_W'(WINDOW_LENGTH - 1)) begin
						ph_q <= P_DRAIN;
					end
				end
				P_DRAIN: ph_q <= P_MUL;
				P_MUL:   ph_q <= P_FIX;
				P_FIX:   ph_q <= P_DONE;
				P_DONE:  ph_q <= P_IDLE;
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == P_IDLE && cmd.start) begin
			rd_addr_q <= cmd.base;
			acc_q     <= '0;
		end else begin
			if (ph_q == P_READ) begin
				rd_addr_q <= rd_addr_q + 1'b1;
			end
			if (rd_vld_q) begin
				acc_q <= acc_q + SUM_W'(rd_data_q);
			end
		end
		if (ph_q == P_MUL) begin
			mag_q  <= mag;
			neg_q  <= acc_q[SUM_W-1];
			prod_q <= PROD_W'(mag) * PROD_W'(RECIP);
		end
		if (ph_q == P_FIX) begin
			avg_q <= neg_q ? 16'(-q_fix) : 16'(q_fix);
		end
	end

	assign res.done = (ph_q == P_DONE);
	assign res.avg  = avg_q;

endmodule

>>> rtl/sensor_window_average_monitor.sv
// ----------------------------------------------------------------------------
// sensor_window_average_monitor
// Maps sensors to rooms and keeps a moving average per sensor. One item is
// taken at a time: req_stall stays high from the accepted beat until its
// result is loaded into the output register. Every item scans the whole slot
// table, one entry per cycle. A sample that completes its window also reads
// the ring one sample per cycle and runs the divide by the window length.
// Thresholds are to be written through the cfg port only while idle, a rule
// the user keeps; the block itself leaves it unenforced.
// ----------------------------------------------------------------------------
module sensor_window_average_monitor import swam_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SUM    = 3'd3;
	localparam logic [2:0] S_OUT    = 3'd4;

	logic [2:0]  state_q;
	logic signed [15:0] min_thr_q;
	logic signed [15:0] max_thr_q;

	logic              valid_q  [TABLE_DEPTH];
	logic [15:0]       sensor_q [TABLE_DEPTH];
	logic [15:0]       room_q   [TABLE_DEPTH];
	logic [31:0]       time_q   [TABLE_DEPTH];
	logic [CNT_W-1:0]  pos_q    [TABLE_DEPTH];
	logic [CNT_W-1:0]  cnt_q    [TABLE_DEPTH];

	req_t              req_q;
	rsp_t              res_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;
	logic [SLOT_W-1:0] scan_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] free_q;
	logic              found_q;
	logic              free_found_q;

	logic              hit;
	logic [CNT_W-1:0]  p_use;
	logic [CNT_W-1:0]  p_next;
	logic [CNT_W-1:0]  pos_new;
	logic [CNT_W-1:0]  cnt_new;
	logic              win_full;
	logic              store;
	logic [WIN_AW-1:0] slot_base;
	rsp_t              dec_res;
	rsp_t              avg_res;

	win_wr_t  win_wr;
	win_cmd_t win_cmd;
	win_res_t win_res;

	always_comb begin
		hit       = valid_q[scan_q] && (sensor_q[scan_q] == req_q.probe_id);
		p_use     = (pos_q[slot_q] >= CNT_W'(WINDOW_LENGTH)) ? '0 : pos_q[slot_q];
		p_next    = p_use + 1'b1;
		pos_new   = (p_next >= CNT_W'(WINDOW_LENGTH)) ? '0 : p_next;
		cnt_new   = (cnt_q[slot_q] < CNT_W'(WINDOW_LENGTH)) ? cnt_q[slot_q] + 1'b1
			: cnt_q[slot_q];
		win_full  = (cnt_new >= CNT_W'(WINDOW_LENGTH));
		store     = (state_q == S_DECIDE) && (req_q.func == FUNC_SAMPLE) && found_q;
		slot_base = WIN_AW'(slot_q * WINDOW_LENGTH);

		win_wr.en     = store;
		win_wr.addr   = slot_base + WIN_AW'(p_use);
		win_wr.data   = req_q.sample_value;
		win_cmd.start = store && win_full;
		win_cmd.base  = slot_base;
	end

	// result of the table decision, and the same with the average folded in
	always_comb begin
		dec_res = '0;
		if (req_q.func == FUNC_MAP) begin
			if (found_q) begin
				dec_res.status         = ST_DUPLICATE;
				dec_res.room_of_sensor = room_q[slot_q];
				dec_res.last_time      = time_q[slot_q];
			end else if (!free_found_q) begin
				dec_res.status = ST_FULL;
			end else begin
				dec_res.status         = ST_MAPPED;
				dec_res.room_of_sensor = req_q.room;
			end
		end else if (!found_q) begin
			dec_res.status = ST_UNMAPPED;
		end else begin
			dec_res.status         = ST_STORED;
			dec_res.room_of_sensor = room_q[slot_q];
			dec_res.last_time      = req_q.sample_time;
		end

		avg_res               = res_q;
		avg_res.average       = win_res.avg;
		avg_res.average_valid = 1'b1;
		avg_res.too_hot       = (win_res.avg > max_thr_q);
		avg_res.too_cold      = (win_res.avg < min_thr_q);
	end

	swam_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (win_wr),
		.cmd    (win_cmd),
		.res    (win_res)
	);

	// control, thresholds and per-slot counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			min_thr_q    <= 16'sh8000;
			max_thr_q    <= 16'sh7FFF;
			rsp_valid_q  <= 1'b0;
			scan_q       <= '0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				valid_q[i] <= 1'b0;
				time_q[i]  <= '0;
				pos_q[i]   <= '0;
				cnt_q[i]   <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MIN_THRESHOLD) begin
					min_thr_q <= cfg_data;
				end else if (cfg_index == CFG_MAX_THRESHOLD) begin
					max_thr_q <= cfg_data;
				end
			end
			if (state_q == S_OUT && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						scan_q       <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit && !found_q) begin
						found_q <= 1'b1;
					end
					if (!valid_q[scan_q] && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					scan_q <= scan_q + 1'b1;
					if (scan_q == SLOT_W'(TABLE_DEPTH - 1)) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= S_OUT;
					if (req_q.func == FUNC_MAP) begin
						if (!found_q && free_found_q) begin
							valid_q[free_q] <= 1'b1;
							time_q[free_q]  <= '0;
							pos_q[free_q]   <= '0;
							cnt_q[free_q]   <= '0;
						end
					end else if (found_q) begin
						pos_q[slot_q]  <= pos_new;
						cnt_q[slot_q]  <= cnt_new;
						time_q[slot_q] <= req_q.sample_time;
						if (win_full) begin
							state_q <= S_SUM;
						end
					end
				end
				S_SUM: begin
					if (win_res.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload: request copy, table ids and rooms, result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					req_q <= req;
				end
			end
			S_SCAN: begin
				if (hit && !found_q) begin
					slot_q <= scan_q;
				end
				if (!valid_q[scan_q] && !free_found_q) begin
					free_q <= scan_q;
				end
			end
			S_DECIDE: begin
				res_q <= dec_res;
				if (req_q.func == FUNC_MAP && !found_q && free_found_q) begin
					sensor_q[free_q] <= req_q.probe_id;
					room_q[free_q]   <= req_q.room;
				end
			end
			S_SUM: begin
				if (win_res.done) begin
					res_q <= avg_res;
				end
			end
			S_OUT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	// a window sum only follows the store of a sample to a mapped sensor
	a_sum_start: assert property (@(posedge clk) disable iff (!arst_n)
		win_cmd.start |-> (found_q && req_q.func == FUNC_SAMPLE))
		else $error("window sum started without a mapped sample");

	// the averaging unit finishes only while the sequencer waits for it
	a_done_in_sum: assert property (@(posedge clk) disable iff (!arst_n)
		win_res.done |-> (state_q == S_SUM))
		else $error("window result outside of sum wait");

	// a matched slot is a live table entry
	a_slot_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && found_q) |-> valid_q[slot_q])
		else $error("matched slot is not valid");

	// an average is only reported on a stored sample beat
	a_avg_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.average_valid) |-> (rsp.status == ST_STORED))
		else $error("average reported on a non-sample beat");

endmodule

>>> sim/room_average_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// room_average_checker
// Follows the sensor table, the sample rings and the thresholds beside the
// monitor. Each request beat taken yields a predicted report; each result
// beat taken is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module room_average_checker import swam_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  req_t                 req,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  rsp_t                 rsp,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output int                   mismatches,
	output int                   awaiting
);

	logic signed [15:0] cold_limit;
	logic signed [15:0] hot_limit;
	logic               slot_used   [TABLE_DEPTH];
	logic [15:0]        slot_sensor [TABLE_DEPTH];
	logic [15:0]        slot_room   [TABLE_DEPTH];
	logic [31:0]        slot_stamp  [TABLE_DEPTH];
	logic signed [15:0] ring        [TABLE_DEPTH][WINDOW_LENGTH];
	int                 ring_pos    [TABLE_DEPTH];
	int                 ring_fill   [TABLE_DEPTH];
	rsp_t               expected_reports [$];
	rsp_t               want;

	function automatic rsp_t next_report(input req_t r);
		rsp_t res;
		int   i;
		int   hit;
		int   free;
		int   sum;
		res  = '0;
		hit  = -1;
		free = -1;
		// walk downward so the lowest matching / free slot is kept
		for (i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (slot_used[i] && slot_sensor[i] == r.probe_id)
				hit = i;
			if (!slot_used[i])
				free = i;
		end
		if (r.func == FUNC_MAP) begin
			if (hit >= 0) begin
				res.status         = ST_DUPLICATE;
				res.room_of_sensor = slot_room[hit];
				res.last_time      = slot_stamp[hit];
			end else if (free < 0) begin
				res.status = ST_FULL;
			end else begin
				slot_used[free]    = 1'b1;
				slot_sensor[free]  = r.probe_id;
				slot_room[free]    = r.room;
				slot_stamp[free]   = '0;
				ring_pos[free]     = 0;
				ring_fill[free]    = 0;
				res.status         = ST_MAPPED;
				res.room_of_sensor = r.room;
			end
		end else if (hit < 0) begin
			res.status = ST_UNMAPPED;
		end else begin
			ring[hit][ring_pos[hit]] = r.sample_value;
			ring_pos[hit] = (ring_pos[hit] + 1) % WINDOW_LENGTH;
			if (ring_fill[hit] < WINDOW_LENGTH)
				ring_fill[hit]++;
			slot_stamp[hit]    = r.sample_time;
			res.status         = ST_STORED;
			res.room_of_sensor = slot_room[hit];
			res.last_time      = r.sample_time;
			if (ring_fill[hit] == WINDOW_LENGTH) begin
				sum = 0;
				for (i = 0; i < WINDOW_LENGTH; i++)
					sum += ring[hit][i];
				// int divide truncates toward zero
				sum               = sum / WINDOW_LENGTH;
				res.average       = 16'(sum);
				res.average_valid = 1'b1;
				res.too_hot       = (sum > hot_limit);
				res.too_cold      = (sum < cold_limit);
			end
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic signed [32:0] exp_val,
			input logic signed [32:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cold_limit = 16'sh8000;
			hot_limit  = 16'sh7FFF;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				slot_used[i]  = 1'b0;
				slot_stamp[i] = '0;
				ring_pos[i]   = 0;
				ring_fill[i]  = 0;
			end
			expected_reports.delete();
			mismatches = 0;
			awaiting   <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MIN_THRESHOLD)
					cold_limit = cfg_data;
				else if (cfg_index == CFG_MAX_THRESHOLD)
					hot_limit = cfg_data;
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_reports.size() == 0) begin
					$error("result beat with no request outstanding");
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("room_of_sensor", want.room_of_sensor, rsp.room_of_sensor);
					check_field("average", want.average, rsp.average);
					check_field("average_valid", want.average_valid, rsp.average_valid);
					check_field("too_hot", want.too_hot, rsp.too_hot);
					check_field("too_cold", want.too_cold, rsp.too_cold);
					check_field("last_time", want.last_time, rsp.last_time);
				end
			end
			if (req_valid && !req_stall)
				expected_reports.push_back(next_report(req));
			awaiting <= expected_reports.size();
		end
	end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives map and sample beats into the sensor window average monitor with
// random gaps and result stalls, changes the thresholds between phases and
// reports the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module tb import swam_pkg::*; ();

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 313;
	localparam int POOL_SIZE     = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_NO_SUCH_REG = '1;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;
	int                   mismatches;
	int                   awaiting;
	int                   cycles = 0;
	bit                   steady_send = 1'b0;
	bit                   steady_take = 1'b0;
	logic [15:0]          sensor_pool [POOL_SIZE];

	always #10 clk = ~clk;

	sensor_window_average_monitor uut (.*);

	room_average_checker watch (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// result side: random stall before each beat, with stretches of none
	initial begin : result_sink
		int hold;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				steady_take = !steady_take;
			hold = steady_take ? 0 : $urandom_range(0, 15);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
		end
	end

	function automatic req_t make_map(input logic [15:0] id, input logic [15:0] room);
		req_t item;
		item.func         = FUNC_MAP;
		item.probe_id     = id;
		item.room         = room;
		item.sample_value = 16'($urandom);
		item.sample_time  = $urandom;
		return item;
	endfunction

	function automatic req_t make_sample(input logic [15:0] id,
			input logic signed [15:0] value, input logic [31:0] stamp);
		req_t item;
		item.func         = FUNC_SAMPLE;
		item.probe_id     = id;
		item.room         = 16'($urandom);
		item.sample_value = value;
		item.sample_time  = stamp;
		return item;
	endfunction

	function automatic req_t random_item();
		req_t item;
		int   roll;
		item.func        = FUNC_SAMPLE;
		item.probe_id    = sensor_pool[$urandom_range(0, POOL_SIZE - 1)];
		item.room        = 16'($urandom);
		item.sample_time = $urandom;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			item.func = FUNC_MAP;
		end else if (roll < 15) begin
			item.func     = FUNC_MAP;
			item.probe_id = 16'($urandom);
		end else if (roll < 25) begin
			item.probe_id = 16'($urandom);
		end
		case ($urandom_range(0, 9))
			0:       item.sample_value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1, 2, 3: item.sample_value = 16'($urandom_range(0, 4000) - 2000);
			default: item.sample_value = 16'($urandom);
		endcase
		return item;
	endfunction

	task automatic send_item(input req_t item);
		int gap;
		if ($urandom_range(0, 39) == 0)
			steady_send = !steady_send;
		gap = steady_send ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// awaiting is registered behind the beat, hence the first clock
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_limits(input logic signed [15:0] cold, input logic signed [15:0] hot,
			input bit stray);
		write_reg(CFG_MIN_THRESHOLD, cold);
		write_reg(CFG_MAX_THRESHOLD, hot);
		// a write to a missing register must leave both limits alone
		if (stray)
			write_reg(CFG_NO_SUCH_REG, 16'h8001);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int                 phase;
		int                 n;
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		sensor_pool[0] = 16'hFFFF;
		sensor_pool[1] = 16'h0000;
		for (n = 2; n < POOL_SIZE; n++)
			sensor_pool[n] = 16'($urandom);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then extreme ids and rooms
		send_item(make_sample(16'h1234, 16'sh0100, 32'd7));
		send_item(make_map(16'hFFFF, 16'hFFFF));
		send_item(make_map(16'h0000, 16'h0000));
		send_item(make_map(16'hFFFF, 16'h5555));
		for (n = 0; n < WINDOW_LENGTH; n++)
			send_item(make_sample(16'hFFFF, 16'sh7FFF, 32'hFFFF_FFFF - n));
		for (n = 0; n < WINDOW_LENGTH; n++)
			send_item(make_sample(16'h0000, 16'sh8000, n));
		// ring wraps over the oldest sample
		send_item(make_sample(16'h0000, 16'sh7FFF, 32'd100));
		send_item(make_map(16'h0000, 16'h1111));

		wait_drained();
		set_limits(16'sh0000, 16'sh0000, 1'b1);
		for (n = 0; n < WINDOW_LENGTH; n++)
			send_item(make_sample(16'h0000, 16'sh0000, 32'd200 + n));
		// small sums of either sign truncate to zero, then large ones
		send_item(make_sample(16'h0000, 16'sh0001, 32'd210));
		send_item(make_sample(16'h0000, -16'sd3, 32'd211));
		send_item(make_sample(16'h0000, 16'sh8000, 32'd212));
		send_item(make_sample(16'hFFFF, -16'sd1, 32'd213));

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			case (phase)
				0: set_limits(16'sh8000, 16'sh7FFF, 1'b0);
				1: set_limits(16'sh7FFF, 16'sh8000, 1'b0);
				default: begin
					lo = 16'($urandom_range(0, 4000) - 2000);
					hi = lo + 16'($urandom_range(0, 3000));
					set_limits(lo, hi, 1'b0);
				end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 149) == 0)
					wait_drained();
				send_item(random_item());
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
